FILE: hdl/pst_pkg.sv
// types and constants of the php subset token scanner
// no dependencies
package pst_pkg;

  localparam int KIND_W = 6;
  localparam int OFS_W = 24;
  localparam int LEN_W = 24;
  localparam int LINE_W = 20;

  typedef enum logic [5:0] {
    K_UNKNOWN = 6'd0, K_START_PHP = 6'd1, K_END_PHP = 6'd2, K_LPAREN = 6'd3,
    K_RPAREN = 6'd4, K_LBRACKET = 6'd5, K_RBRACKET = 6'd6, K_LBRACE = 6'd7,
    K_RBRACE = 6'd8, K_PERIOD = 6'd9, K_COLON = 6'd10, K_SEMI = 6'd11,
    K_COMMA = 6'd12, K_AMP = 6'd13, K_STRING = 6'd14, K_NUMBER = 6'd15,
    K_FLOAT = 6'd16, K_IDENT = 6'd17, K_VAR = 6'd18, K_TRUE = 6'd19,
    K_FALSE = 6'd20, K_NULL = 6'd21, K_IF = 6'd22, K_ELSE = 6'd23, K_FOR = 6'd24,
    K_FOREACH = 6'd25, K_AS = 6'd26, K_ARROW = 6'd27, K_FUNCTION = 6'd28,
    K_BREAK = 6'd29, K_CONTINUE = 6'd30, K_RETURN = 6'd31, K_ASSIGN = 6'd32,
    K_ASSIGN_MUL = 6'd33, K_ASSIGN_DIV = 6'd34, K_ASSIGN_ADD = 6'd35,
    K_ASSIGN_SUB = 6'd36, K_ASSIGN_CAT = 6'd37, K_MUL = 6'd38, K_DIV = 6'd39,
    K_ADD = 6'd40, K_INC = 6'd41, K_SUB = 6'd42, K_DEC = 6'd43, K_LT = 6'd44,
    K_LE = 6'd45, K_GT = 6'd46, K_GE = 6'd47, K_EQ = 6'd48, K_NE = 6'd49,
    K_SEQ = 6'd50, K_SNE = 6'd51, K_LAND = 6'd52, K_LOR = 6'd53, K_EOS = 6'd54
  } kind_t;

  typedef enum logic [1:0] {
    CC_OTHER = 2'd0, CC_LETTER = 2'd1, CC_DIGIT = 2'd2, CC_UNDER = 2'd3
  } cclass_t;

  // one token headed for the output stage
  typedef struct packed {
    kind_t              kind;
    logic [OFS_W-1:0]   ofs;
    logic [LEN_W-1:0]   len;
    logic [LINE_W-1:0]  line;
    logic               last;
  } tok_t;

  localparam int TOK_W = $bits(tok_t);

  // what the front hands the back for every byte
  typedef struct packed {
    logic [7:0] ch;
    cclass_t    cc;
  } cbyte_t;

  function automatic logic [63:0] kw_pack(input int n, input logic [63:0] s);
    kw_pack = s & ((n >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << (8 * n)) - 64'd1));
  endfunction

  function automatic kind_t kw_lookup(input logic [63:0] w);
    kind_t k;
    k = K_IDENT;
    unique case (w)
      64'h6966: k = K_IF;
      64'h656c7365: k = K_ELSE;
      64'h666f72: k = K_FOR;
      64'h666f7265616368: k = K_FOREACH;
      64'h6173: k = K_AS;
      64'h66756e6374696f6e: k = K_FUNCTION;
      64'h627265616b: k = K_BREAK;
      64'h636f6e74696e7565: k = K_CONTINUE;
      64'h72657475726e: k = K_RETURN;
      64'h74727565: k = K_TRUE;
      64'h66616c7365: k = K_FALSE;
      64'h6e756c6c: k = K_NULL;
      default: k = K_IDENT;
    endcase
    kw_lookup = k;
  endfunction

endpackage

FILE: hdl/pst_front.sv
// front: accepts text bytes, classifies each, and pushes them into the queue
// depends on pst_pkg
module pst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  output logic              q_wr,
  output pst_pkg::cbyte_t   q_wdata,
  input  logic              q_full
);

  pst_pkg::cclass_t cc;

  always_comb begin
    cc = pst_pkg::CC_OTHER;
    if ((in_tdata >= 8'h61 && in_tdata <= 8'h7a) || (in_tdata >= 8'h41 && in_tdata <= 8'h5a))
      cc = pst_pkg::CC_LETTER;
    else if (in_tdata >= 8'h30 && in_tdata <= 8'h39)
      cc = pst_pkg::CC_DIGIT;
    else if (in_tdata == 8'h5f)
      cc = pst_pkg::CC_UNDER;
  end

  assign in_tready = rst_n && !q_full;
  assign q_wr = in_tvalid && in_tready;
  assign q_wdata = '{ch: in_tdata, cc: cc};

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !q_wr)
    else $error("push into full queue");
  a_class_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr && q_wdata.cc == pst_pkg::CC_DIGIT) |-> (q_wdata.ch >= 8'h30 && q_wdata.ch <= 8'h39))
    else $error("bad digit class");
  a_class_under: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr && q_wdata.ch == 8'h5f) |-> (q_wdata.cc == pst_pkg::CC_UNDER))
    else $error("bad underscore class");
`endif

endmodule

FILE: hdl/pst_queue.sv
// short fifo between front and back
// depends on pst_pkg
module pst_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  pst_pkg::cbyte_t  wdata,
  output logic             full,
  input  logic             rd,
  output pst_pkg::cbyte_t  rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pst_pkg::cbyte_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

`ifndef ASSERT_OFF
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !rd)
    else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("count slip");
  a_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(DEPTH))
    else $error("count over depth");
`endif

endmodule

FILE: hdl/pst_back.sv
// back: scanning state machine, emits up to two tokens per byte
// depends on pst_pkg
module pst_back #(
  parameter int POS_BITS = 24,
  parameter int LINE_BITS = 20,
  parameter int KEYWORD_CHARS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  pst_pkg::cbyte_t  q_rdata,
  output logic             q_rd,
  output logic             out_tvalid,
  input  logic             out_tready,
  output pst_pkg::tok_t    out_tok
);

  localparam int WCAP = (KEYWORD_CHARS < 8) ? KEYWORD_CHARS : 8;
  localparam logic [POS_BITS-1:0] PMAX = '1;
  localparam logic [LINE_BITS-1:0] LMAX = '1;

  typedef enum logic [4:0] {
    M_IDLE, M_SLASH, M_LINE_CMT, M_BLOCK_CMT, M_BLOCK_STAR, M_AMP, M_BAR,
    M_BANG, M_BANG_EQ, M_EQ, M_EQ_EQ, M_STAR, M_PLUS, M_MINUS, M_DOT, M_LT,
    M_LT_Q, M_GT, M_QUEST, M_STRING, M_VAR, M_WORD, M_NUMBER
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt, pstart_r, pstart_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt, pline_r, pline_nxt;
  logic [63:0] word_r, word_nxt;
  logic        olong_r, olong_nxt;

  // two-entry output buffer
  pst_pkg::tok_t ob_r [2];
  logic [1:0]    ocnt_r;
  logic          ohead_r;

  pst_pkg::tok_t t0, t1;
  logic v0, v1;
  logic [7:0] b;
  logic is_let, is_dig, is_wc;
  logic fire;

  function automatic logic [pst_pkg::OFS_W-1:0] sat_o(input logic [POS_BITS-1:0] v);
    if (POS_BITS > pst_pkg::OFS_W && (v >> pst_pkg::OFS_W) != '0) sat_o = '1;
    else sat_o = pst_pkg::OFS_W'(v);
  endfunction

  function automatic logic [pst_pkg::LINE_W-1:0] sat_l(input logic [LINE_BITS-1:0] v);
    if (LINE_BITS > pst_pkg::LINE_W && (v >> pst_pkg::LINE_W) != '0) sat_l = '1;
    else sat_l = pst_pkg::LINE_W'(v);
  endfunction

  function automatic pst_pkg::tok_t mk(input pst_pkg::kind_t k,
      input logic [POS_BITS-1:0] s, input logic [POS_BITS:0] n,
      input logic [LINE_BITS-1:0] l);
    pst_pkg::tok_t t;
    t.kind = k;
    t.ofs = sat_o(s);
    if (POS_BITS + 1 > pst_pkg::LEN_W && (n >> pst_pkg::LEN_W) != '0) t.len = '1;
    else t.len = pst_pkg::LEN_W'(n);
    t.line = sat_l(l);
    t.last = 1'b0;
    mk = t;
  endfunction

  assign b = q_rdata.ch;
  assign is_let = (q_rdata.cc == pst_pkg::CC_LETTER);
  assign is_dig = (q_rdata.cc == pst_pkg::CC_DIGIT);
  assign is_wc = (q_rdata.cc != pst_pkg::CC_OTHER);

  // a byte is taken only when the buffer is empty or drains this cycle to room
  assign fire = !q_empty && (ocnt_r == 2'd0 || (ocnt_r == 2'd1 && out_tready));
  assign q_rd = fire;

  always_comb begin
    logic consumed, eos, fin, fl;
    pst_pkg::kind_t fk;
    logic [POS_BITS:0] lf, lfl;
    mode_nxt = mode_r;
    pos_nxt = pos_r;
    pstart_nxt = pstart_r;
    line_nxt = line_r;
    pline_nxt = pline_r;
    word_nxt = word_r;
    olong_nxt = olong_r;
    v0 = 1'b0;
    v1 = 1'b0;
    consumed = 1'b1;
    eos = 1'b0;
    fin = 1'b0;
    fl = 1'b0;
    fk = pst_pkg::K_UNKNOWN;
    lf = {1'b0, pos_r} + 1'b1 - {1'b0, pstart_r};
    lfl = {1'b0, pos_r} - {1'b0, pstart_r};
    t1 = mk(pst_pkg::K_UNKNOWN, pos_r, (POS_BITS+1)'(1), line_r);

    unique case (mode_r)
      M_IDLE: consumed = 1'b0;
      M_SLASH:
        if (b == "/") mode_nxt = M_LINE_CMT;
        else if (b == "*") mode_nxt = M_BLOCK_CMT;
        else if (b == "=") begin fin = 1'b1; fk = pst_pkg::K_ASSIGN_DIV; end
        else begin fl = 1'b1; fk = pst_pkg::K_DIV; end
      M_LINE_CMT:
        if (b == 8'h00 || b == 8'h0a || b == 8'h0d) begin
          mode_nxt = M_IDLE;
          consumed = 1'b0;
        end
      M_BLOCK_CMT, M_BLOCK_STAR:
        if (b == 8'h00) begin
          mode_nxt = M_IDLE;
          consumed = 1'b0;
        end else if (mode_r == M_BLOCK_STAR && b == "/") mode_nxt = M_IDLE;
        else begin
          if (b == 8'h0a && line_r != LMAX) line_nxt = line_r + 1'b1;
          mode_nxt = (b == "*") ? M_BLOCK_STAR : M_BLOCK_CMT;
        end
      M_AMP: begin fk = (b == "&") ? pst_pkg::K_LAND : pst_pkg::K_AMP;
        fin = (b == "&"); fl = !fin; end
      M_BAR: begin fk = (b == "|") ? pst_pkg::K_LOR : pst_pkg::K_UNKNOWN;
        fin = (b == "|"); fl = !fin; end
      M_BANG:
        if (b == "=") mode_nxt = M_BANG_EQ;
        else begin fl = 1'b1; fk = pst_pkg::K_UNKNOWN; end
      M_BANG_EQ: begin fk = (b == "=") ? pst_pkg::K_SNE : pst_pkg::K_NE;
        fin = (b == "="); fl = !fin; end
      M_EQ:
        if (b == "=") mode_nxt = M_EQ_EQ;
        else begin fk = (b == ">") ? pst_pkg::K_ARROW : pst_pkg::K_ASSIGN;
          fin = (b == ">"); fl = !fin; end
      M_EQ_EQ: begin fk = (b == "=") ? pst_pkg::K_SEQ : pst_pkg::K_EQ;
        fin = (b == "="); fl = !fin; end
      M_STAR: begin fk = (b == "=") ? pst_pkg::K_ASSIGN_MUL : pst_pkg::K_MUL;
        fin = (b == "="); fl = !fin; end
      M_PLUS: begin
        fin = (b == "+" || b == "=");
        fl = !fin;
        fk = (b == "+") ? pst_pkg::K_INC : (b == "=") ? pst_pkg::K_ASSIGN_ADD : pst_pkg::K_ADD;
      end
      M_MINUS: begin
        fin = (b == "-" || b == "=");
        fl = !fin;
        fk = (b == "-") ? pst_pkg::K_DEC : (b == "=") ? pst_pkg::K_ASSIGN_SUB : pst_pkg::K_SUB;
      end
      M_DOT: begin fk = (b == "=") ? pst_pkg::K_ASSIGN_CAT : pst_pkg::K_PERIOD;
        fin = (b == "="); fl = !fin; end
      M_LT:
        if (b == "?") mode_nxt = M_LT_Q;
        else begin fk = (b == "=") ? pst_pkg::K_LE : pst_pkg::K_LT;
          fin = (b == "="); fl = !fin; end
      M_LT_Q:
        if (!is_let) begin fl = 1'b1; fk = pst_pkg::K_START_PHP; end
      M_GT: begin fk = (b == "=") ? pst_pkg::K_GE : pst_pkg::K_GT;
        fin = (b == "="); fl = !fin; end
      M_QUEST: begin fk = (b == ">") ? pst_pkg::K_END_PHP : pst_pkg::K_UNKNOWN;
        fin = (b == ">"); fl = !fin; end
      M_STRING:
        if (b == "'") begin fin = 1'b1; fk = pst_pkg::K_STRING; end
        else if (b == 8'h00) begin fl = 1'b1; fk = pst_pkg::K_STRING; end
      M_VAR:
        if (!is_wc) begin fl = 1'b1; fk = pst_pkg::K_VAR; end
      M_WORD:
        if (is_wc) begin
          if (!olong_r) begin
            if (word_r[8*(WCAP-1) +: 8] != 8'h00) olong_nxt = 1'b1;
            else word_nxt = {word_r[55:0], b};
          end
        end else begin
          fl = 1'b1;
          fk = olong_r ? pst_pkg::K_IDENT : pst_pkg::kw_lookup(word_r);
        end
      M_NUMBER:
        if (!is_dig) begin fl = 1'b1; fk = pst_pkg::K_NUMBER; end
      default: begin
        mode_nxt = M_IDLE;
        consumed = 1'b0;
      end
    endcase

    if (fin || fl) begin
      mode_nxt = M_IDLE;
      consumed = fin;
      v0 = 1'b1;
    end
    t0 = mk(fk, pstart_r, fin ? lf : lfl, pline_r);

    if (!consumed) begin
      v1 = 1'b1;
      priority case (1'b1)
        b == 8'h00: begin t1.kind = pst_pkg::K_EOS; eos = 1'b1; end
        b == 8'h0a: begin v1 = 1'b0; if (line_r != LMAX) line_nxt = line_r + 1'b1; end
        b == 8'h20 || b == 8'h09 || b == 8'h0b || b == 8'h0c || b == 8'h0d: v1 = 1'b0;
        b == "(": t1.kind = pst_pkg::K_LPAREN;
        b == ")": t1.kind = pst_pkg::K_RPAREN;
        b == "[": t1.kind = pst_pkg::K_LBRACKET;
        b == "]": t1.kind = pst_pkg::K_RBRACKET;
        b == "{": t1.kind = pst_pkg::K_LBRACE;
        b == "}": t1.kind = pst_pkg::K_RBRACE;
        b == ":": t1.kind = pst_pkg::K_COLON;
        b == ";": t1.kind = pst_pkg::K_SEMI;
        b == ",": t1.kind = pst_pkg::K_COMMA;
        default: begin
          v1 = 1'b0;
          pstart_nxt = pos_r;
          pline_nxt = line_r;
          priority case (1'b1)
            b == "/": mode_nxt = M_SLASH;
            b == "&": mode_nxt = M_AMP;
            b == "|": mode_nxt = M_BAR;
            b == "!": mode_nxt = M_BANG;
            b == "=": mode_nxt = M_EQ;
            b == "*": mode_nxt = M_STAR;
            b == "+": mode_nxt = M_PLUS;
            b == "-": mode_nxt = M_MINUS;
            b == ".": mode_nxt = M_DOT;
            b == "<": mode_nxt = M_LT;
            b == ">": mode_nxt = M_GT;
            b == "?": mode_nxt = M_QUEST;
            b == "'": mode_nxt = M_STRING;
            b == "$": mode_nxt = M_VAR;
            is_let: begin
              mode_nxt = M_WORD;
              word_nxt = {56'd0, b};
              olong_nxt = 1'b0;
            end
            is_dig: mode_nxt = M_NUMBER;
            default: begin
              pstart_nxt = pstart_r;
              pline_nxt = pline_r;
              v1 = 1'b1;
            end
          endcase
        end
      endcase
    end

    if (v1) t1.last = 1'b1;
    else t0.last = 1'b1;

    if (eos) begin
      mode_nxt = M_IDLE;
      pos_nxt = '0;
      pstart_nxt = '0;
      line_nxt = '0;
      pline_nxt = '0;
      word_nxt = '0;
      olong_nxt = 1'b0;
    end else if (pos_r != PMAX) pos_nxt = pos_r + 1'b1;
  end

  assign out_tvalid = (ocnt_r != 2'd0);
  assign out_tok = ob_r[ohead_r];

  always_ff @(posedge clk) begin
    if (fire) begin
      if (v0) ob_r[0] <= t0;
      if (v0) ob_r[1] <= t1;
      else ob_r[0] <= t1;
    end
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r <= '0;
      pstart_r <= '0;
      line_r <= '0;
      pline_r <= '0;
      word_r <= '0;
      olong_r <= 1'b0;
      ocnt_r <= '0;
      ohead_r <= 1'b0;
    end else begin
      if (fire) begin
        mode_r <= mode_nxt;
        pos_r <= pos_nxt;
        pstart_r <= pstart_nxt;
        line_r <= line_nxt;
        pline_r <= pline_nxt;
        word_r <= word_nxt;
        olong_r <= olong_nxt;
        ocnt_r <= 2'(v0) + 2'(v1);
        ohead_r <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        ocnt_r <= ocnt_r - 1'b1;
        ohead_r <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ocnt_r == 2'd1) |-> out_tready)
    else $error("byte taken over a held token");
  a_eos_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tok.kind == pst_pkg::K_EOS) |-> out_tok.last)
    else $error("end token not last");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) ocnt_r != 2'd3)
    else $error("output count overflow");
`endif

endmodule

FILE: hdl/php_subset_token_scanner_top.sv
// top level of the php subset token scanner
// depends on pst_pkg, pst_front, pst_queue, pst_back
//
// Source bytes enter on in_* (byte 0 ends the text and makes the block reset
// its position and line counts after emitting EndOfStream); tokens leave on
// out_*, up to two per byte, the last of each byte marked by out_tlast. The
// front classifies one byte per cycle into a four-entry queue unless it is full,
// and the back scanner takes one queued byte per cycle whenever its two-token
// output buffer has room, so with no output stall throughput is one byte per
// cycle for one-token bytes; a byte of two tokens stalls the back until one drains.
module php_subset_token_scanner_top #(
  parameter int POS_BITS = 24,
  parameter int LINE_BITS = 20,
  parameter int KEYWORD_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // token_kind, start_offset, token_length, start_line, pad
  output logic        out_tlast   // last_of_run
);

  logic q_wr, q_full, q_rd, q_empty;
  pst_pkg::cbyte_t q_wdata, q_rdata;
  pst_pkg::tok_t tok;

  pst_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .q_wr(q_wr), .q_wdata(q_wdata), .q_full(q_full)
  );

  pst_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr(q_wr), .wdata(q_wdata), .full(q_full),
    .rd(q_rd), .rdata(q_rdata), .empty(q_empty)
  );

  pst_back #(
    .POS_BITS(POS_BITS), .LINE_BITS(LINE_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_rdata(q_rdata), .q_rd(q_rd),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tok(tok)
  );

  assign out_tdata = {6'd0, tok.line, tok.len, tok.ofs, tok.kind};
  assign out_tlast = tok.last;

endmodule

FILE: tb/testbench.sv
// self-checking testbench for php_subset_token_scanner_top
// depends on pst_pkg and the scanner rtl; predicts tokens per source byte
`timescale 1ns / 100ps

class token_scoreboard;
  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] ofs;
    logic [23:0] len;
    logic [19:0] line;
    logic        last;
  } tok_exp_t;

  typedef enum int {
    S_IDLE, S_SLASH, S_LINE_CMT, S_BLOCK_CMT, S_BLOCK_STAR, S_AMP, S_BAR,
    S_BANG, S_BANG_EQ, S_EQ, S_EQ_EQ, S_STAR, S_PLUS, S_MINUS, S_DOT, S_LT,
    S_LT_Q, S_GT, S_QUEST, S_STRING, S_VAR, S_WORD, S_NUMBER
  } scan_state_t;

  tok_exp_t    pending_tokens[$];
  scan_state_t mode;
  logic [23:0] tok_start, pos;
  logic [19:0] tok_line, line_no;
  logic [63:0] prefix;
  bit          overlong;
  int          errors, tokens_seen, eos_seen;
  tok_exp_t    step_toks[$];

  function new();
    errors = 0;
    tokens_seen = 0;
    eos_seen = 0;
    clear_state();
  endfunction

  function void clear_state();
    mode = S_IDLE;
    tok_start = '0;
    tok_line = '0;
    pos = '0;
    line_no = '0;
    prefix = '0;
    overlong = 0;
  endfunction

  function void push_tok(pst_pkg::kind_t k, logic [23:0] s, logic [23:0] l, logic [19:0] ln);
    tok_exp_t t;
    t.kind = k;
    t.ofs = s;
    t.len = l;
    t.line = ln;
    t.last = 0;
    step_toks.push_back(t);
  endfunction

  function bit finish_tok(pst_pkg::kind_t k);
    logic [24:0] n;
    // length can reach one past the field maximum once the position saturates
    n = {1'b0, pos} + 25'd1 - {1'b0, tok_start};
    push_tok(k, tok_start, n[24] ? 24'hFF_FFFF : n[23:0], tok_line);
    mode = S_IDLE;
    return 1;
  endfunction

  function bit flush_tok(pst_pkg::kind_t k);
    push_tok(k, tok_start, pos - tok_start, tok_line);
    mode = S_IDLE;
    return 0;
  endfunction

  function bit pick(logic [7:0] b, logic [7:0] c, pst_pkg::kind_t hit, pst_pkg::kind_t miss);
    if (b == c) return finish_tok(hit);
    return flush_tok(miss);
  endfunction

  static function bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  static function bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function pst_pkg::kind_t word_to_kind();
    if (overlong) return pst_pkg::K_IDENT;
    case (prefix)
      64'h6966: return pst_pkg::K_IF;
      64'h656c7365: return pst_pkg::K_ELSE;
      64'h666f72: return pst_pkg::K_FOR;
      64'h666f7265616368: return pst_pkg::K_FOREACH;
      64'h6173: return pst_pkg::K_AS;
      64'h66756e6374696f6e: return pst_pkg::K_FUNCTION;
      64'h627265616b: return pst_pkg::K_BREAK;
      64'h636f6e74696e7565: return pst_pkg::K_CONTINUE;
      64'h72657475726e: return pst_pkg::K_RETURN;
      64'h74727565: return pst_pkg::K_TRUE;
      64'h66616c7365: return pst_pkg::K_FALSE;
      64'h6e756c6c: return pst_pkg::K_NULL;
      default: return pst_pkg::K_IDENT;
    endcase
  endfunction

  function void open_tok(scan_state_t m);
    mode = m;
    tok_start = pos;
    tok_line = line_no;
  endfunction

  // returns 1 when the current mode swallowed the byte
  function bit continue_tok(logic [7:0] b);
    case (mode)
      S_IDLE: return 0;
      S_SLASH: begin
        if (b == "/") begin mode = S_LINE_CMT; return 1; end
        if (b == "*") begin mode = S_BLOCK_CMT; return 1; end
        return pick(b, "=", pst_pkg::K_ASSIGN_DIV, pst_pkg::K_DIV);
      end
      S_LINE_CMT: begin
        if (b == 0 || b == 8'h0a || b == 8'h0d) begin mode = S_IDLE; return 0; end
        return 1;
      end
      S_BLOCK_CMT, S_BLOCK_STAR: begin
        if (b == 0) begin mode = S_IDLE; return 0; end
        if (mode == S_BLOCK_STAR && b == "/") begin mode = S_IDLE; return 1; end
        if (b == 8'h0a && line_no != '1) line_no++;
        mode = (b == "*") ? S_BLOCK_STAR : S_BLOCK_CMT;
        return 1;
      end
      S_AMP: return pick(b, "&", pst_pkg::K_LAND, pst_pkg::K_AMP);
      S_BAR: return pick(b, "|", pst_pkg::K_LOR, pst_pkg::K_UNKNOWN);
      S_BANG: begin
        if (b == "=") begin mode = S_BANG_EQ; return 1; end
        return flush_tok(pst_pkg::K_UNKNOWN);
      end
      S_BANG_EQ: return pick(b, "=", pst_pkg::K_SNE, pst_pkg::K_NE);
      S_EQ: begin
        if (b == "=") begin mode = S_EQ_EQ; return 1; end
        return pick(b, ">", pst_pkg::K_ARROW, pst_pkg::K_ASSIGN);
      end
      S_EQ_EQ: return pick(b, "=", pst_pkg::K_SEQ, pst_pkg::K_EQ);
      S_STAR: return pick(b, "=", pst_pkg::K_ASSIGN_MUL, pst_pkg::K_MUL);
      S_PLUS: begin
        if (b == "+") return finish_tok(pst_pkg::K_INC);
        return pick(b, "=", pst_pkg::K_ASSIGN_ADD, pst_pkg::K_ADD);
      end
      S_MINUS: begin
        if (b == "-") return finish_tok(pst_pkg::K_DEC);
        return pick(b, "=", pst_pkg::K_ASSIGN_SUB, pst_pkg::K_SUB);
      end
      S_DOT: return pick(b, "=", pst_pkg::K_ASSIGN_CAT, pst_pkg::K_PERIOD);
      S_LT: begin
        if (b == "?") begin mode = S_LT_Q; return 1; end
        return pick(b, "=", pst_pkg::K_LE, pst_pkg::K_LT);
      end
      S_LT_Q: begin
        if (is_letter(b)) return 1;
        return flush_tok(pst_pkg::K_START_PHP);
      end
      S_GT: return pick(b, "=", pst_pkg::K_GE, pst_pkg::K_GT);
      S_QUEST: return pick(b, ">", pst_pkg::K_END_PHP, pst_pkg::K_UNKNOWN);
      S_STRING: begin
        if (b == "'") return finish_tok(pst_pkg::K_STRING);
        if (b == 0) return flush_tok(pst_pkg::K_STRING);
        return 1;
      end
      S_VAR: begin
        if (is_letter(b) || is_digit(b) || b == "_") return 1;
        return flush_tok(pst_pkg::K_VAR);
      end
      S_WORD: begin
        if (is_letter(b) || is_digit(b) || b == "_") begin
          if (!overlong) begin
            if (prefix[63:56] != 0) overlong = 1;
            else prefix = {prefix[55:0], b};
          end
          return 1;
        end
        return flush_tok(word_to_kind());
      end
      S_NUMBER: begin
        if (is_digit(b)) return 1;
        return flush_tok(pst_pkg::K_NUMBER);
      end
      default: begin mode = S_IDLE; return 0; end
    endcase
  endfunction

  // returns 1 at end of text
  function bit start_tok(logic [7:0] b);
    case (b)
      8'h00: begin push_tok(pst_pkg::K_EOS, pos, 24'd1, line_no); return 1; end
      8'h0a: begin if (line_no != '1) line_no++; end
      8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d: ;
      "(": push_tok(pst_pkg::K_LPAREN, pos, 24'd1, line_no);
      ")": push_tok(pst_pkg::K_RPAREN, pos, 24'd1, line_no);
      "[": push_tok(pst_pkg::K_LBRACKET, pos, 24'd1, line_no);
      "]": push_tok(pst_pkg::K_RBRACKET, pos, 24'd1, line_no);
      "{": push_tok(pst_pkg::K_LBRACE, pos, 24'd1, line_no);
      "}": push_tok(pst_pkg::K_RBRACE, pos, 24'd1, line_no);
      ":": push_tok(pst_pkg::K_COLON, pos, 24'd1, line_no);
      ";": push_tok(pst_pkg::K_SEMI, pos, 24'd1, line_no);
      ",": push_tok(pst_pkg::K_COMMA, pos, 24'd1, line_no);
      "/": open_tok(S_SLASH);
      "&": open_tok(S_AMP);
      "|": open_tok(S_BAR);
      "!": open_tok(S_BANG);
      "=": open_tok(S_EQ);
      "*": open_tok(S_STAR);
      "+": open_tok(S_PLUS);
      "-": open_tok(S_MINUS);
      ".": open_tok(S_DOT);
      "<": open_tok(S_LT);
      ">": open_tok(S_GT);
      "?": open_tok(S_QUEST);
      "'": open_tok(S_STRING);
      "$": open_tok(S_VAR);
      default: begin
        if (is_letter(b)) begin
          open_tok(S_WORD);
          prefix = {56'd0, b};
          overlong = 0;
        end else if (is_digit(b)) open_tok(S_NUMBER);
        else push_tok(pst_pkg::K_UNKNOWN, pos, 24'd1, line_no);
      end
    endcase
    return 0;
  endfunction

  function void note_byte(logic [7:0] b);
    bit ended;
    step_toks.delete();
    ended = 0;
    if (!continue_tok(b)) ended = start_tok(b);
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1;
    foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
    if (ended) clear_state();
    else if (pos != '1) pos++;
  endfunction

  task check_token(logic [79:0] data, logic last);
    tok_exp_t e;
    tokens_seen++;
    if (data[5:0] == pst_pkg::K_EOS) eos_seen++;
    if (pending_tokens.size() == 0) begin
      report("unexpected token", data, last, '0);
      return;
    end
    e = pending_tokens.pop_front();
    if (data[5:0] != e.kind) report("kind", data, last, e);
    if (data[29:6] != e.ofs) report("offset", data, last, e);
    if (data[53:30] != e.len) report("length", data, last, e);
    if (data[73:54] != e.line) report("line", data, last, e);
    if (last != e.last) report("tlast", data, last, e);
  endtask

  task report(string what, logic [79:0] data, logic last, tok_exp_t e);
    errors++;
    $display({"mismatch %s at %0t: got k=%0d o=%0d l=%0d ln=%0d last=%0b,",
              " exp k=%0d o=%0d l=%0d ln=%0d last=%0b"},
             what, $time, data[5:0], data[29:6], data[53:30], data[73:54], last,
             e.kind, e.ofs, e.len, e.line, e.last);
  endtask
endclass

module testbench;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [79:0] out_tdata;
  logic        out_tlast;

  token_scoreboard tokens = new();
  bit   calm = 0;
  int   quiet_cycles = 0;
  int   bytes_sent = 0;
  localparam int QUIET_LIMIT = 5000;

  php_subset_token_scanner_top dut (.*);

  always #5 clk = ~clk;

  // receive side: accept and check, with random stall bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tokens.check_token(out_tdata, out_tlast);
  end

  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      out_tready <= 1;
      n = $urandom_range(1, 40);
      repeat (n) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // watchdog: cycles with no accepted beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout waiting for traffic");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    tokens.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // a random fragment of plausible source
  task automatic send_fragment();
    int n;
    string frags[] = '{"if", "else", "for", "foreach", "as", "function", "break",
                       "continue", "return", "true", "false", "null", "foreachx",
                       "functions", "x_9", "===", "!==", "==", "!=", "=>", "&&",
                       "||", "<=", ">=", "++", "--", "+=", "-=", "*=", "/=", ".=",
                       "?>", "<?php", "<?", "// c\n", "/* a*\n*/", "'s\n'", "$v_1",
                       "$", "12345", "\n", " ", "\t", "\r", "(", ")", "[", "]",
                       "{", "}", ";", ",", ":", "&", "|", "!", "?", "_a", "@"};
    case ($urandom_range(0, 9))
      0: send_byte(8'($urandom_range(1, 255)));
      1: begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(8'("a" + $urandom_range(0, 25)));
      end
      default: send_text(frags[$urandom_range(0, frags.size()-1)]);
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: operators, keywords, comments, strings, unknowns
    send_text("<?php if($a_1===$b){x!==y;}else foreach(z as $k=>$v)");
    send_byte(0);
    send_text("a&&b||c|d!e?>f<=g>=h<i>j.=k.l+=m++n-=o--p*=q*r/=s/t==u=v&w");
    send_byte(0);
    send_text("function continue return true false null break for verylongname");
    send_byte(0);
    send_text("x // line\ny /* bl\nock **/ 'str\ning' 007 ");
    send_byte(8'hff); send_byte(8'h80); send_byte(8'h7f); send_byte("_");
    send_byte(0);
    send_text("'open");
    send_byte(0);
    send_text("/* open");
    send_byte(0);
    send_text("// open");
    send_byte(0);
    send_text("ident");
    send_byte(0);
    // random part
    while (bytes_sent < 1350) begin
      if (bytes_sent > 1200) calm = 1;
      send_fragment();
      if ($urandom_range(0, 40) == 0) send_byte(0);
    end
    send_byte(0);
    in_tvalid <= 0;
    while (tokens.pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d source bytes, checked %0d tokens over %0d texts",
             bytes_sent, tokens.tokens_seen, tokens.eos_seen);
    if (tokens.errors == 0 && tokens.pending_tokens.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
